// ----- hw/rtl/scan_code_to_character_decoder_top_assert.svh -----
// Assertion macros for the scan code decoder.
// Expects clk and arst_n to be in scope where the macros are used.
`ifndef SCAN_CODE_TO_CHARACTER_DECODER_TOP_ASSERT_SVH
`define SCAN_CODE_TO_CHARACTER_DECODER_TOP_ASSERT_SVH

// checked on every rising edge once out of reset
`define SCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define SCD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/scd_pkg.sv -----
// Shared types, codes and key tables for the scan code decoder.
// No dependencies.
package scd_pkg;

	typedef enum logic [2:0] {
		EV_CHAR    = 3'd0,
		EV_MEMORY  = 3'd1,
		EV_TASKS   = 3'd2,
		EV_VERSION = 3'd3,
		EV_REBOOT  = 3'd4
	} event_kind_t;

	typedef enum logic [1:0] {
		PRE_NONE = 2'd0,
		PRE_E0   = 2'd1,
		PRE_E1   = 2'd2
	} prefix_t;

	// modifier bit positions
	localparam int unsigned MOD_W     = 6;
	localparam int unsigned MOD_SHIFT = 0;
	localparam int unsigned MOD_CTRL  = 1;
	localparam int unsigned MOD_LALT  = 2;
	localparam int unsigned MOD_RALT  = 3;
	localparam int unsigned MOD_NUM   = 4;
	localparam int unsigned MOD_CAPS  = 5;

	// scan codes with a role of their own
	localparam logic [7:0] SC_PFX_E0    = 8'hE0;
	localparam logic [7:0] SC_PFX_E1    = 8'hE1;
	localparam logic [7:0] SC_BREAK     = 8'h80;
	localparam logic [7:0] SC_LSHIFT    = 8'h2A;
	localparam logic [7:0] SC_RSHIFT    = 8'h36;
	localparam logic [7:0] SC_CTRL      = 8'h1D;
	localparam logic [7:0] SC_ALT       = 8'h38;
	localparam logic [7:0] SC_CAPS      = 8'h3A;
	localparam logic [7:0] SC_NUM       = 8'h45;
	localparam logic [7:0] SC_DEL       = 8'h53;
	localparam logic [7:0] SC_SPACE     = 8'h39;
	localparam logic [7:0] SC_BACKSLASH = 8'h56;

	function automatic logic is_char_key(input logic [7:0] c);
		logic r;
		if (c >= 8'h01 && c <= 8'h35)
			r = (c != SC_CTRL) && (c != SC_LSHIFT);
		else
			r = (c == SC_SPACE) || (c == SC_BACKSLASH);
		return r;
	endfunction

	// unshifted UK layout
	function automatic logic [7:0] plain_lut(input logic [6:0] c);
		logic [7:0] r;
		case (c)
			7'h01: r = 8'h1B;
			7'h02: r = 8'h31; 7'h03: r = 8'h32; 7'h04: r = 8'h33; 7'h05: r = 8'h34;
			7'h06: r = 8'h35; 7'h07: r = 8'h36; 7'h08: r = 8'h37; 7'h09: r = 8'h38;
			7'h0A: r = 8'h39; 7'h0B: r = 8'h30; 7'h0C: r = 8'h2D; 7'h0D: r = 8'h3D;
			7'h0E: r = 8'h08; 7'h0F: r = 8'h09;
			7'h10: r = 8'h71; 7'h11: r = 8'h77; 7'h12: r = 8'h65; 7'h13: r = 8'h72;
			7'h14: r = 8'h74; 7'h15: r = 8'h79; 7'h16: r = 8'h75; 7'h17: r = 8'h69;
			7'h18: r = 8'h6F; 7'h19: r = 8'h70; 7'h1A: r = 8'h5B; 7'h1B: r = 8'h5D;
			7'h1C: r = 8'h0A;
			7'h1E: r = 8'h61; 7'h1F: r = 8'h73; 7'h20: r = 8'h64; 7'h21: r = 8'h66;
			7'h22: r = 8'h67; 7'h23: r = 8'h68; 7'h24: r = 8'h6A; 7'h25: r = 8'h6B;
			7'h26: r = 8'h6C; 7'h27: r = 8'h3B; 7'h28: r = 8'h27; 7'h29: r = 8'h60;
			7'h2B: r = 8'h23;
			7'h2C: r = 8'h7A; 7'h2D: r = 8'h78; 7'h2E: r = 8'h63; 7'h2F: r = 8'h76;
			7'h30: r = 8'h62; 7'h31: r = 8'h6E; 7'h32: r = 8'h6D; 7'h33: r = 8'h2C;
			7'h34: r = 8'h2E; 7'h35: r = 8'h2F;
			7'h39: r = 8'h20;
			7'h56: r = 8'h5C;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// shifted UK layout, pound and not sign as Latin-1
	function automatic logic [7:0] shift_lut(input logic [6:0] c);
		logic [7:0] r;
		case (c)
			7'h01: r = 8'h1B;
			7'h02: r = 8'h21; 7'h03: r = 8'h22; 7'h04: r = 8'hA3; 7'h05: r = 8'h24;
			7'h06: r = 8'h25; 7'h07: r = 8'h5E; 7'h08: r = 8'h26; 7'h09: r = 8'h2A;
			7'h0A: r = 8'h28; 7'h0B: r = 8'h29; 7'h0C: r = 8'h5F; 7'h0D: r = 8'h2B;
			7'h0E: r = 8'h08; 7'h0F: r = 8'h09;
			7'h10: r = 8'h51; 7'h11: r = 8'h57; 7'h12: r = 8'h45; 7'h13: r = 8'h52;
			7'h14: r = 8'h54; 7'h15: r = 8'h59; 7'h16: r = 8'h55; 7'h17: r = 8'h49;
			7'h18: r = 8'h4F; 7'h19: r = 8'h50; 7'h1A: r = 8'h7B; 7'h1B: r = 8'h7D;
			7'h1C: r = 8'h0A;
			7'h1E: r = 8'h41; 7'h1F: r = 8'h53; 7'h20: r = 8'h44; 7'h21: r = 8'h46;
			7'h22: r = 8'h47; 7'h23: r = 8'h48; 7'h24: r = 8'h4A; 7'h25: r = 8'h4B;
			7'h26: r = 8'h4C; 7'h27: r = 8'h3A; 7'h28: r = 8'h40; 7'h29: r = 8'hAC;
			7'h2B: r = 8'h7E;
			7'h2C: r = 8'h5A; 7'h2D: r = 8'h58; 7'h2E: r = 8'h43; 7'h2F: r = 8'h56;
			7'h30: r = 8'h42; 7'h31: r = 8'h4E; 7'h32: r = 8'h4D; 7'h33: r = 8'h3C;
			7'h34: r = 8'h3E; 7'h35: r = 8'h3F;
			7'h39: r = 8'h20;
			7'h56: r = 8'h7C;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/scan_code_to_character_decoder_top.sv -----
// Scan code decoder: input register, one pass of decode logic, result register.
// An accepted code passes the input register, then the result register; one code per cycle while out_stall is low.
// The throughput is set by the single decode pass between input and result registers.
// A code that gives no result still passes the decode stage and updates the state.
// arst_n clears prefix, modifiers and both valid flags; payloads are not reset.
// Depends on scd_pkg and scan_code_to_character_decoder_top_assert.svh.
`include "scan_code_to_character_decoder_top_assert.svh"

module scan_code_to_character_decoder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          scan_code,
	output logic                out_valid,
	input  logic                out_stall,
	output scd_pkg::event_kind_t event_kind,
	output logic [7:0]          character,
	output logic [scd_pkg::MOD_W-1:0] modifier_flags
);
	import scd_pkg::*;

	logic             valid_s1;
	logic [7:0]       code_s1;
	prefix_t          prefix_q;
	logic [MOD_W-1:0] mods_q;

	logic             out_free;
	logic             fire;
	logic             in_accept;

	prefix_t          prefix_d;
	logic [MOD_W-1:0] mods_d;
	logic             has_res;
	event_kind_t      kind_d;
	logic [7:0]       char_d;
	logic [7:0]       lut_ch;
	logic             brk;

	// handshake: output slot frees when empty or taken
	assign out_free  = !out_valid || !out_stall;
	assign fire      = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			code_s1 <= scan_code;
		end
	end

	// decode
	assign brk    = (code_s1 & SC_BREAK) != 8'h00;
	assign lut_ch = (mods_q[MOD_SHIFT] ^ mods_q[MOD_CAPS]) ? shift_lut(code_s1[6:0])
	                                                       : plain_lut(code_s1[6:0]);

	always_comb begin
		prefix_d = PRE_NONE;
		mods_d   = mods_q;
		has_res  = 1'b0;
		kind_d   = EV_CHAR;
		char_d   = 8'h00;
		if (code_s1 == SC_PFX_E0) begin
			prefix_d = PRE_E0;
		end else if (code_s1 == SC_PFX_E1) begin
			prefix_d = PRE_E1;
		end else if (is_char_key(code_s1)) begin
			if (mods_q[MOD_CTRL]) begin
				// hotkeys, either case
				if (lut_ch == 8'h6D || lut_ch == 8'h4D) begin
					has_res = 1'b1;
					kind_d  = EV_MEMORY;
				end else if (lut_ch == 8'h70 || lut_ch == 8'h50) begin
					has_res = 1'b1;
					kind_d  = EV_TASKS;
				end else if (lut_ch == 8'h76 || lut_ch == 8'h56) begin
					has_res = 1'b1;
					kind_d  = EV_VERSION;
				end
			end else begin
				has_res = 1'b1;
				char_d  = lut_ch;
			end
		end else if (code_s1[6:0] == SC_LSHIFT[6:0] || code_s1[6:0] == SC_RSHIFT[6:0]) begin
			mods_d[MOD_SHIFT] = !brk;
		end else if (code_s1[6:0] == SC_CTRL[6:0]) begin
			mods_d[MOD_CTRL] = !brk;
		end else if (code_s1[6:0] == SC_ALT[6:0]) begin
			if (prefix_q == PRE_E0)
				mods_d[MOD_RALT] = !brk;
			else
				mods_d[MOD_LALT] = !brk;
		end else if (code_s1 == SC_CAPS) begin
			mods_d[MOD_CAPS] = !mods_q[MOD_CAPS];
		end else if (code_s1 == SC_NUM) begin
			mods_d[MOD_NUM] = !mods_q[MOD_NUM];
		end else if (code_s1 == SC_DEL) begin
			if (mods_q[MOD_CTRL] && (mods_q[MOD_LALT] || mods_q[MOD_RALT])) begin
				has_res = 1'b1;
				kind_d  = EV_REBOOT;
			end
		end
	end

	// decoder state, advanced as each beat leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= PRE_NONE;
			mods_q   <= '0;
		end else if (fire) begin
			prefix_q <= prefix_d;
			mods_q   <= mods_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= fire && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_res) begin
			event_kind     <= kind_d;
			character      <= char_d;
			modifier_flags <= mods_d;
		end
	end

	// checks
	`SCD_ASSERT(a_reboot_mods, (out_valid && event_kind == EV_REBOOT) |-> (modifier_flags[MOD_CTRL] && (modifier_flags[MOD_LALT] || modifier_flags[MOD_RALT])), "reboot without ctrl and alt")
	`SCD_ASSERT(a_event_no_char, (out_valid && event_kind != EV_CHAR) |-> (character == 8'h00), "event beat carries a character")
	`SCD_ASSERT(a_char_no_ctrl, (out_valid && event_kind == EV_CHAR) |-> !modifier_flags[MOD_CTRL], "character emitted with ctrl held")
	`SCD_ASSERT(a_prefix_no_beat, (fire && (code_s1 == SC_PFX_E0 || code_s1 == SC_PFX_E1)) |=> (prefix_q != PRE_NONE), "prefix byte not remembered")
	`SCD_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (!out_valid && !valid_s1), "beat pending in reset")

endmodule
